// ===== hdl/pgm_pkg.sv =====
// Shared constants, codes and control types of the path glob matcher.
package pgm_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int FUNC_W = 2;
  localparam int CH_W = 8;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PATH   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_END    = 2'd3;

  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic clear;
    logic append;
    logic restart;
    logic load;
    logic close;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic closed;
  } dp_stat_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } result_t;

endpackage

// ===== hdl/pgm_cmd_if.sv =====
// Command channel of the path glob matcher: function code and byte.
interface pgm_cmd_if;
  import pgm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CH_W-1:0]   ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink (input valid, input func, input ch, output ready);
endinterface

// ===== hdl/pgm_res_if.sv =====
// Result channel of the path glob matcher: match and overflow flags.
interface pgm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic too_long;

  modport source (output valid, output matched, output too_long, input ready);
  modport sink (input valid, input matched, input too_long, output ready);
endinterface

// ===== hdl/path_glob_matcher.sv =====
// Top level of the path glob matcher: controller, datapath and result buffer.
//
// Items arrive on cmd as a function code and a byte. Clear empties the stored
// pattern, append adds one pattern byte, a path byte advances the match, and
// end of path produces one item on res carrying matched and too_long.
// A path byte is taken and then occupies the datapath for the star-skip rounds
// that still add positions to the active set, then for the step that consumes
// it; the number of rounds is bounded by the longest chain of stars that jump
// into one another, since every round runs one skip for all pattern positions
// in parallel. The result of an end of path is registered into a two-entry
// result buffer between the datapath and res, and shows on res once earlier
// results are taken. The block keeps taking items while a result waits;
// cmd.ready falls while a path byte occupies the datapath, and when both
// entries are full, until the receiver takes one.
// After reset the pattern is empty, the overflow flag is clear, no result is
// pending and only position zero is active. The pattern bytes themselves are
// not cleared; the stored length alone tells which of them count.
// A pattern that grows beyond PATTERN_MAX bytes keeps its first bytes, flags
// too_long on every result and forces matched low until the next clear.
module path_glob_matcher #(
  parameter int PATTERN_MAX = pgm_pkg::PATTERN_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  pgm_cmd_if.sink    cmd,
  pgm_res_if.source  res
);
  import pgm_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;
  result_t  result;
  result_t  res_item;
  logic     push;
  logic     ob_full;

  pgm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .valid   (cmd.valid),
    .func    (cmd.func),
    .ob_full (ob_full),
    .stat    (stat),
    .ready   (cmd.ready),
    .ctl     (ctl),
    .push    (push)
  );

  pgm_dp #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .ch     (cmd.ch),
    .stat   (stat),
    .result (result)
  );

  pgm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (result),
    .pop_ready (res.ready),
    .valid     (res.valid),
    .dout      (res_item),
    .full      (ob_full)
  );

  assign res.matched  = res_item.matched;
  assign res.too_long = res_item.too_long;
endmodule

// ===== hdl/pgm_dp.sv =====
// Datapath: pattern registers, per-position flags and the active position vector.
module pgm_dp #(
  parameter int PATTERN_MAX = pgm_pkg::PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pgm_pkg::dp_cmd_t      ctl,
  input  logic [pgm_pkg::CH_W-1:0] ch,
  output pgm_pkg::dp_stat_t     stat,
  output pgm_pkg::result_t      result
);
  import pgm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int NP = PATTERN_MAX + 1;

  logic [CH_W-1:0]        pat [PATTERN_MAX];
  logic [LW-1:0]          len;
  logic [PATTERN_MAX-1:0] inpat;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] quest;
  logic [PATTERN_MAX-1:0] dstar;
  logic [PATTERN_MAX-1:0] dslash;
  logic [NP-1:0]          tail_ok;
  logic [NP-1:0]          act;
  logic [NP-1:0]          add;
  logic [NP-1:0]          nxt;
  logic                   ovf;
  logic [CH_W-1:0]        chr;
  logic                   full;
  logic                   slash;

  assign full  = (len == LW'(PATTERN_MAX));
  assign slash = (chr == CH_SLASH);

  // Pattern bytes; each cell compares its own byte, so no reset is needed.
  always_ff @(posedge clk) begin
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (ctl.append && !full && len == LW'(p)) begin
        pat[p] <= ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      len     <= '0;
      inpat   <= '0;
      star    <= '0;
      quest   <= '0;
      dstar   <= '0;
      dslash  <= '0;
      tail_ok <= NP'(1);
      ovf     <= 1'b0;
    end else if (ctl.append) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        len <= len + LW'(1);
        for (int p = 0; p < PATTERN_MAX; p++) begin
          if (len == LW'(p)) begin
            inpat[p] <= 1'b1;
            star[p]  <= (ch == CH_STAR);
            quest[p] <= (ch == CH_QUEST);
          end
        end
        for (int p = 1; p < PATTERN_MAX; p++) begin
          if (len == LW'(p) && ch == CH_STAR && star[p-1]) begin
            dstar[p-1] <= 1'b1;
          end
        end
        for (int p = 2; p < PATTERN_MAX; p++) begin
          if (len == LW'(p) && ch == CH_SLASH && dstar[p-2]) begin
            dslash[p-2] <= 1'b1;
          end
        end
        // Positions from which only stars remain up to the pattern end.
        if (ch == CH_STAR) begin
          for (int q = 1; q < NP; q++) begin
            if (len == LW'(q - 1)) begin
              tail_ok[q] <= 1'b1;
            end
          end
        end else begin
          tail_ok <= NP'(1) << (len + LW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      chr <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      act <= NP'(1);
    end else if (ctl.close) begin
      act <= act | add;
    end else if (ctl.step) begin
      act <= nxt;
    end
  end

  // One round of star skips: an active star hands activity past its token.
  always_comb begin
    add = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (act[p] && star[p]) begin
        if (dslash[p]) begin
          if (p + 3 < NP) add[p+3] = 1'b1;
        end else if (dstar[p]) begin
          if (p + 2 < NP) add[p+2] = 1'b1;
        end else begin
          add[p+1] = 1'b1;
        end
      end
    end
  end

  // Consumption of one path byte by every active position at once.
  always_comb begin
    nxt = '0;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      if (act[p] && inpat[p]) begin
        if (star[p]) begin
          if (dstar[p]) begin
            nxt[p] = 1'b1;
            if (dslash[p]) begin
              if (p + 3 < NP) nxt[p+3] = 1'b1;
            end else begin
              if (p + 2 < NP) nxt[p+2] = 1'b1;
            end
          end else if (!slash) begin
            nxt[p] = 1'b1;
          end
        end else if (quest[p]) begin
          if (!slash) nxt[p+1] = 1'b1;
        end else if (pat[p] == chr) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
  end

  assign stat.closed     = ~|(add & ~act);
  assign result.matched  = !ovf && |(act & tail_ok);
  assign result.too_long = ovf;

`ifndef NO_ASSERTIONS
  a_restart_one : assert property (@(posedge clk) disable iff (rst)
    ctl.restart |=> act == NP'(1))
    else $error("active set not restarted to position zero");
  a_close_grows : assert property (@(posedge clk) disable iff (rst)
    ctl.close |=> $countones(act) > $past($countones(act)))
    else $error("closure round added no position");
  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
    ovf |-> len == LW'(PATTERN_MAX))
    else $error("overflow flagged below capacity");
  a_tail_end : assert property (@(posedge clk) disable iff (rst)
    tail_ok[len])
    else $error("pattern end not an accepting position");
`endif
endmodule

// ===== hdl/pgm_ctrl.sv =====
// Controller: decodes accepted items and sequences the star closure rounds.
module pgm_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  input  logic [pgm_pkg::FUNC_W-1:0] func,
  input  logic                       ob_full,
  input  pgm_pkg::dp_stat_t          stat,
  output logic                       ready,
  output pgm_pkg::dp_cmd_t           ctl,
  output logic                       push
);
  import pgm_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CLOSE = 1'b1;

  logic state;
  logic state_next;
  logic acc;

  assign ready = (state == ST_IDLE) && !ob_full;
  assign acc   = valid && ready;

  always_comb begin
    ctl        = '0;
    push       = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (func)
            FUNC_CLEAR: begin
              ctl.clear   = 1'b1;
              ctl.restart = 1'b1;
            end
            FUNC_APPEND: begin
              ctl.append  = 1'b1;
              ctl.restart = 1'b1;
            end
            FUNC_PATH: begin
              ctl.load   = 1'b1;
              state_next = ST_CLOSE;
            end
            default: begin
              push        = 1'b1;
              ctl.restart = 1'b1;
            end
          endcase
        end
      end
      default: begin
        if (stat.closed) begin
          ctl.step   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.close = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== hdl/pgm_obuf.sv =====
// Two-entry result buffer between the matcher and the result channel.
module pgm_obuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pgm_pkg::result_t din,
  input  logic             pop_ready,
  output logic             valid,
  output pgm_pkg::result_t dout,
  output logic             full
);
  import pgm_pkg::*;

  logic [1:0] count;
  result_t    head;
  result_t    tail;
  logic       pop;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = head;
  assign pop   = valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      head <= din;
    end else if (pop && count == 2'd2) begin
      head <= tail;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      tail <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end
endmodule
